// ===== design/sdfac_pkg.sv =====
// Shared types and constants for the antialiased circle pixel shader.
// Depends on nothing; every other design file imports it.

package sdfac_pkg;

    localparam int COLOR_BITS     = 24;
    localparam int CHAN_BITS      = 8;
    localparam int NUM_CHAN       = 3;
    localparam int RADIUS_BITS    = 9;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 3;
    localparam int OUTLINE_HALF   = 4;
    localparam int SOLID_HALF     = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_RADIUS     = 3'd2,
        CFG_DRAW_COLOR = 3'd3,
        CFG_SOLID_MODE = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [RADIUS_BITS-1:0] radius;
        logic [COLOR_BITS-1:0]  draw_color;
        logic                   solid_mode;
    } t_shade_cfg;

endpackage

// ===== design/sdfac_front.sv =====
// Front stages: centre offsets, their squares and the scaled squared distance.
// Depends on sdfac_pkg.

module sdfac_front
    import sdfac_pkg::*;
#(
    parameter int COORD_BITS     = 11,
    parameter int DIST_FRAC_BITS = 4,
    parameter int ROOT_BITS      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_BITS-1:0]  i_pixel_x,
    input  logic signed [COORD_BITS-1:0]  i_pixel_y,
    input  logic [COLOR_BITS-1:0]         i_bg,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2*ROOT_BITS-1:0]        o_q,
    output logic [COLOR_BITS-1:0]         o_bg
);

    localparam int SQ_BITS  = 2 * COORD_BITS;
    localparam int PAD_BITS = 2 * ROOT_BITS - (SQ_BITS + 1) - 2 * DIST_FRAC_BITS;

    logic                       r_v1, r_v2, r_v3;
    logic                       rdy1, rdy2, rdy3;
    logic [COORD_BITS-1:0]      r_adx, r_ady;
    logic [COLOR_BITS-1:0]      r_bg1, r_bg2, r_bg3;
    logic [SQ_BITS-1:0]         r_sqx, r_sqy;
    logic [2*ROOT_BITS-1:0]     r_q;
    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        adx, ady;
    logic [SQ_BITS:0]           sum;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_q     = r_q;
    assign o_bg    = r_bg3;

    always_comb begin
        dx  = {i_pixel_x[COORD_BITS-1], i_pixel_x} - {i_center_x[COORD_BITS-1], i_center_x};
        dy  = {i_pixel_y[COORD_BITS-1], i_pixel_y} - {i_center_y[COORD_BITS-1], i_center_y};
        adx = dx[COORD_BITS] ? -dx : dx;
        ady = dy[COORD_BITS] ? -dy : dy;
        sum = {1'b0, r_sqx} + {1'b0, r_sqy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_adx <= adx[COORD_BITS-1:0];
            r_ady <= ady[COORD_BITS-1:0];
            r_bg1 <= i_bg;
        end
        if (rdy2 && r_v1) begin
            r_sqx <= r_adx * r_adx;
            r_sqy <= r_ady * r_ady;
            r_bg2 <= r_bg1;
        end
        if (rdy3 && r_v2) begin
            r_q   <= {{PAD_BITS{1'b0}}, sum, {(2*DIST_FRAC_BITS){1'b0}}};
            r_bg3 <= r_bg2;
        end
    end

endmodule

// ===== design/sdfac_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit from two radicand bits.
// Depends on sdfac_pkg.

module sdfac_sqrt_cell
    import sdfac_pkg::*;
#(
    parameter int ROOT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2*ROOT_BITS-1:0] i_q,
    input  logic [ROOT_BITS:0]     i_rem,
    input  logic [ROOT_BITS-1:0]   i_root,
    input  logic [COLOR_BITS-1:0]  i_bg,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2*ROOT_BITS-1:0] o_q,
    output logic [ROOT_BITS:0]     o_rem,
    output logic [ROOT_BITS-1:0]   o_root,
    output logic [COLOR_BITS-1:0]  o_bg
);

    logic                   r_v;
    logic                   rdy;
    logic [2*ROOT_BITS-1:0] r_q;
    logic [ROOT_BITS:0]     r_rem;
    logic [ROOT_BITS-1:0]   r_root;
    logic [COLOR_BITS-1:0]  r_bg;
    logic [ROOT_BITS+2:0]   acc;
    logic [ROOT_BITS+2:0]   trial;
    logic [ROOT_BITS+2:0]   diff;
    logic [ROOT_BITS:0]     n_rem;
    logic [ROOT_BITS-1:0]   n_root;

    assign rdy     = !r_v || i_ready;
    assign o_ready = rdy;
    assign o_valid = r_v;
    assign o_q     = r_q;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_bg    = r_bg;

    always_comb begin
        acc   = {i_rem, i_q[2*ROOT_BITS-1 -: 2]};
        trial = {1'b0, i_root, 2'b01};
        diff  = acc - trial;
        if (acc >= trial) begin
            n_rem  = diff[ROOT_BITS:0];
            n_root = {i_root[ROOT_BITS-2:0], 1'b1};
        end else begin
            n_rem  = acc[ROOT_BITS:0];
            n_root = {i_root[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_q    <= {i_q[2*ROOT_BITS-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_bg   <= i_bg;
        end
    end

endmodule

// ===== design/sdfac_shade.sv =====
// Back stages: signed distance, coverage alpha, per-channel blend and output register.
// Depends on sdfac_pkg.

module sdfac_shade
    import sdfac_pkg::*;
#(
    parameter int ROOT_BITS       = 16,
    parameter int DIST_FRAC_BITS  = 4,
    parameter int ALPHA_FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_shade_cfg            i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ROOT_BITS-1:0]  i_root,
    input  logic [COLOR_BITS-1:0] i_bg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_write_enable,
    output logic [COLOR_BITS-1:0] o_pixel_color
);

    localparam int F     = DIST_FRAC_BITS;
    localparam int A     = ALPHA_FRAC_BITS;
    localparam int TW    = A + 3;
    localparam int K     = TW + 2;
    localparam int PW    = TW + K;
    localparam int BW    = CHAN_BITS + A + 1;
    localparam logic [K-1:0] RECIP3 = K'((2 ** K) / SOLID_HALF);
    localparam logic [ROOT_BITS-1:0] BAND_OUTLINE = ROOT_BITS'(OUTLINE_HALF * (2 ** F));
    localparam logic [ROOT_BITS-1:0] BAND_SOLID   = ROOT_BITS'(SOLID_HALF * (2 ** F));
    localparam logic [A:0] ALPHA_ONE = {1'b1, {A{1'b0}}};

    logic                    r_v1, r_v2, r_v3, r_v4, r_v5;
    logic                    rdy1, rdy2, rdy3, rdy4, rdy5;
    logic [TW-1:0]           r_t1, r_t2;
    logic [PW-1:0]           r_prod;
    logic [A:0]              r_alpha;
    logic [BW-1:0]           r_pbg [NUM_CHAN];
    logic [BW-1:0]           r_pfg [NUM_CHAN];
    logic                    r_we1, r_we2, r_we3, r_we4, r_we5;
    logic                    r_in1, r_in2, r_in3, r_in4;
    logic                    r_solid2;
    logic [COLOR_BITS-1:0]   r_bg1, r_bg2, r_bg3;
    logic [COLOR_BITS-1:0]   r_color;

    logic signed [ROOT_BITS:0] d;
    logic [ROOT_BITS:0]        ad_full;
    logic [ROOT_BITS-1:0]      ad;
    logic [ROOT_BITS-1:0]      band;
    logic                      interior;
    logic                      in_band;
    logic [F+A+2:0]            ad_scaled;
    logic [TW-1:0]             q0;
    logic [TW+1:0]             rem3;
    logic [TW-1:0]             quot;
    logic [A:0]                inv_alpha;
    logic [BW:0]               mix;
    logic [COLOR_BITS-1:0]     blended;

    assign rdy5           = !r_v5 || i_ready;
    assign rdy4           = !r_v4 || rdy5;
    assign rdy3           = !r_v3 || rdy4;
    assign rdy2           = !r_v2 || rdy3;
    assign rdy1           = !r_v1 || rdy2;
    assign o_ready        = rdy1;
    assign o_valid        = r_v5;
    assign o_write_enable = r_we5;
    assign o_pixel_color  = r_color;

    always_comb begin
        d = $signed({1'b0, i_root})
            - $signed({{(ROOT_BITS + 1 - RADIUS_BITS - F){1'b0}}, i_cfg.radius, {F{1'b0}}});
        ad_full   = d[ROOT_BITS] ? -d : d;
        ad        = ad_full[ROOT_BITS-1:0];
        band      = i_cfg.solid_mode ? BAND_SOLID : BAND_OUTLINE;
        interior  = i_cfg.solid_mode && d[ROOT_BITS];
        in_band   = ad <= band;
        ad_scaled = {ad[F+2:0], {A{1'b0}}};

        q0   = r_prod[PW-1:K];
        rem3 = {2'b00, r_t2} - ({2'b00, q0} + {1'b0, q0, 1'b0});
        if (r_solid2) begin
            quot = (rem3 >= (TW+2)'(SOLID_HALF)) ? q0 + TW'(1) : q0;
        end else begin
            quot = {2'b00, r_t2[TW-1:2]};
        end

        inv_alpha = ALPHA_ONE - r_alpha;

        blended = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            mix = {1'b0, r_pbg[c]} + {1'b0, r_pfg[c]};
            blended[c*CHAN_BITS +: CHAN_BITS] = mix[A +: CHAN_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_t1  <= ad_scaled[F+A+2:F];
            r_we1 <= interior || in_band;
            r_in1 <= interior;
            r_bg1 <= i_bg;
        end
        if (rdy2 && r_v1) begin
            r_prod   <= r_t1 * RECIP3;
            r_t2     <= r_t1;
            r_solid2 <= i_cfg.solid_mode;
            r_we2    <= r_we1;
            r_in2    <= r_in1;
            r_bg2    <= r_bg1;
        end
        if (rdy3 && r_v2) begin
            r_alpha <= ALPHA_ONE - quot[A:0];
            r_we3   <= r_we2;
            r_in3   <= r_in2;
            r_bg3   <= r_bg2;
        end
        if (rdy4 && r_v3) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_pbg[c] <= r_bg3[c*CHAN_BITS +: CHAN_BITS] * inv_alpha;
                r_pfg[c] <= i_cfg.draw_color[c*CHAN_BITS +: CHAN_BITS] * r_alpha;
            end
            r_we4 <= r_we3;
            r_in4 <= r_in3;
        end
        if (rdy5 && r_v4) begin
            r_we5 <= r_we4;
            if (r_in4) begin
                r_color <= i_cfg.draw_color;
            end else if (r_we4) begin
                r_color <= blended;
            end else begin
                r_color <= '0;
            end
        end
    end

endmodule

// ===== design/sdf_antialiased_circle_pixel_core.sv =====
// Antialiased circle pixel shader driven by signed distance to a configured circle.
// A pixel enters every clock unless back-pressure stalls the pipeline. Three front stages
// form the squared distance, a chain of square-root cells settles one root bit per cell,
// and five back stages derive alpha, blend the colour and hold the result in the output
// register. Throughput is one pixel per clock while the output is ready; each stage holds
// its item while the next is full, so while a result waits the input is still taken until
// every stage holds a pixel, and the ready path runs back through the stages. Configuration
// writes are taken on the cycle the write enable is high and are meant for an empty
// pipeline. Depends on sdfac_pkg, sdfac_front, sdfac_sqrt_cell and sdfac_shade.

module sdf_antialiased_circle_pixel_core
    import sdfac_pkg::*;
#(
    parameter int COORD_BITS      = 11,
    parameter int DIST_FRAC_BITS  = 4,
    parameter int ALPHA_FRAC_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // pixel_x, pixel_y, background_color, zero fill
    input  logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // pixel_color
    output logic [COLOR_BITS-1:0]       o_m_axis_tdata,
    // write_enable
    output logic                        o_m_axis_tuser,
    input  logic                        i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int ROOT_BITS = COORD_BITS + DIST_FRAC_BITS + 1;

    logic signed [COORD_BITS-1:0] r_center_x;
    logic signed [COORD_BITS-1:0] r_center_y;
    t_shade_cfg                   r_cfg;

    logic                   f_valid, f_ready;
    logic [2*ROOT_BITS-1:0] f_q;
    logic [COLOR_BITS-1:0]  f_bg;

    logic                   c_valid [ROOT_BITS+1];
    logic                   c_ready [ROOT_BITS+1];
    logic [2*ROOT_BITS-1:0] c_q     [ROOT_BITS+1];
    logic [ROOT_BITS:0]     c_rem   [ROOT_BITS+1];
    logic [ROOT_BITS-1:0]   c_root  [ROOT_BITS+1];
    logic [COLOR_BITS-1:0]  c_bg    [ROOT_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x       <= COORD_BITS'(320);
            r_center_y       <= COORD_BITS'(360);
            r_cfg.radius     <= '0;
            r_cfg.draw_color <= '0;
            r_cfg.solid_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CENTER_X:   r_center_x       <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:   r_center_y       <= i_cfg_data[COORD_BITS-1:0];
                CFG_RADIUS:     r_cfg.radius     <= i_cfg_data[RADIUS_BITS-1:0];
                CFG_DRAW_COLOR: r_cfg.draw_color <= i_cfg_data[COLOR_BITS-1:0];
                CFG_SOLID_MODE: r_cfg.solid_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    sdfac_front #(
        .COORD_BITS     (COORD_BITS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS),
        .ROOT_BITS      (ROOT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_pixel_x  (i_s_axis_tdata[COORD_BITS-1:0]),
        .i_pixel_y  (i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_bg       (i_s_axis_tdata[2*COORD_BITS +: COLOR_BITS]),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_q        (f_q),
        .o_bg       (f_bg)
    );

    assign c_valid[0] = f_valid;
    assign f_ready    = c_ready[0];
    assign c_q[0]     = f_q;
    assign c_rem[0]   = '0;
    assign c_root[0]  = '0;
    assign c_bg[0]    = f_bg;

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
        sdfac_sqrt_cell #(
            .ROOT_BITS (ROOT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_q     (c_q[g]),
            .i_rem   (c_rem[g]),
            .i_root  (c_root[g]),
            .i_bg    (c_bg[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_q     (c_q[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_root  (c_root[g+1]),
            .o_bg    (c_bg[g+1])
        );
    end

    sdfac_shade #(
        .ROOT_BITS       (ROOT_BITS),
        .DIST_FRAC_BITS  (DIST_FRAC_BITS),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_shade (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (c_valid[ROOT_BITS]),
        .o_ready        (c_ready[ROOT_BITS]),
        .i_root         (c_root[ROOT_BITS]),
        .i_bg           (c_bg[ROOT_BITS]),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_write_enable (o_m_axis_tuser),
        .o_pixel_color  (o_m_axis_tdata)
    );

endmodule
